// ===== hdl/sxq_pkg.sv =====
// Shared types, protocol constants and the identity string ROM for the
// system-exclusive device query responder. No dependencies.
`default_nettype none

package sxq_pkg;

    // Configuration register indexes
    localparam logic CFG_OWN_ID  = 1'b0;
    localparam logic CFG_BOOT_ID = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] OWN_ID_RESET  = 8'd50;
    localparam logic [7:0] BOOT_ID_RESET = 8'd64;

    // Fixed message header F0 00 00 7E and frame bytes
    localparam logic [7:0] SYX_START  = 8'hF0;
    localparam logic [7:0] HDR_BYTE1  = 8'h00;
    localparam logic [7:0] HDR_BYTE2  = 8'h00;
    localparam logic [7:0] HDR_BYTE3  = 8'h7E;
    localparam logic [7:0] SYX_END    = 8'hF7;
    localparam logic [7:0] RESP_CODE  = 8'h0F;

    // Commands that ask for an identity response
    localparam logic [7:0] CMD_QUERY     = 8'h00;
    localparam logic [7:0] CMD_QUERY_ALT = 8'h01;

    // Query type codes
    localparam logic [7:0] QRY_BOARD   = 8'h02;
    localparam logic [7:0] QRY_CORE    = 8'h03;
    localparam logic [7:0] QRY_CHIP    = 8'h04;
    localparam logic [7:0] QRY_SERIAL  = 8'h05;
    localparam logic [7:0] QRY_FLASH   = 8'h06;
    localparam logic [7:0] QRY_RAM     = 8'h07;
    localparam logic [7:0] QRY_VERSION = 8'h09;

    // Byte positions within an incoming message
    localparam int          POS_W      = 4;
    localparam logic [3:0]  POS_PROTO  = 4'd4;
    localparam logic [3:0]  POS_INST   = 4'd5;
    localparam logic [3:0]  POS_CMD    = 4'd6;
    localparam logic [3:0]  POS_QUERY  = 4'd7;
    localparam logic [3:0]  POS_MAX    = 4'd15;

    // Item index within one result group (verdict plus up to 21 frame bytes)
    localparam int FRAME_IDX_W = 5;
    localparam int STR_LEN_W   = 4;
    localparam int STR_BITS    = 104;

    typedef enum logic [2:0] {
        STR_NAME,
        STR_BOARD,
        STR_CORE,
        STR_CHIP,
        STR_SERIAL,
        STR_FLASH,
        STR_RAM,
        STR_VERSION
    } str_sel_t;

    // One finished message, handed from front to back
    typedef struct packed {
        logic       handled;
        logic       respond;
        logic [7:0] instance_byte;
        str_sel_t   str_sel;
        logic [3:0] cable;
    } job_t;

    // One result beat
    typedef struct packed {
        logic       item_kind;
        logic       handled;
        logic [7:0] frame_byte;
        logic [3:0] out_cable;
        logic       last;
    } out_item_t;

    function automatic logic [STR_LEN_W-1:0] str_len(input str_sel_t sel);
        logic [STR_LEN_W-1:0] len;
        case (sel)
            STR_BOARD:   len = 4'd13;
            STR_CORE:    len = 4'd7;
            STR_CHIP:    len = 4'd8;
            STR_SERIAL:  len = 4'd6;
            STR_FLASH:   len = 4'd7;
            STR_RAM:     len = 4'd6;
            STR_VERSION: len = 4'd5;
            default:     len = 4'd8;
        endcase
        return len;
    endfunction

    // Strings are right-aligned: the first character sits highest
    function automatic logic [STR_BITS-1:0] str_text(input str_sel_t sel);
        logic [STR_BITS-1:0] text;
        case (sel)
            STR_BOARD:   text = STR_BITS'("GENERIC-BOARD");
            STR_CORE:    text = STR_BITS'("CORE-A1");
            STR_CHIP:    text = STR_BITS'("00000000");
            STR_SERIAL:  text = STR_BITS'("000001");
            STR_FLASH:   text = STR_BITS'("1048576");
            STR_RAM:     text = STR_BITS'("131072");
            STR_VERSION: text = STR_BITS'("1.0.0");
            default:     text = STR_BITS'("SXDEVICE");
        endcase
        return text;
    endfunction

    function automatic logic [7:0] str_char(input str_sel_t sel,
                                            input logic [STR_LEN_W-1:0] pos);
        logic [STR_BITS-1:0]  text;
        logic [STR_LEN_W-1:0] len;
        logic [STR_LEN_W-1:0] rev;
        text = str_text(sel);
        len  = str_len(sel);
        rev  = len - 4'd1 - pos;
        if (pos >= len) begin
            return 8'h00;
        end
        return text[{rev, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sysex_device_query_responder.sv =====
// System-exclusive device query responder, top level: configuration
// registers, front end, job queue, back end and result queue. Uses sxq_pkg.
//
// Takes one message byte per cycle and never stalls between messages while
// the job queue (JOB_DEPTH entries) has room; every byte waits while it is
// full, though only the last byte of a message takes a job slot. Each finished
// message yields a verdict beat and, for an identity query to the own id, a
// response frame of 13 to 21 bytes. The back end emits one beat per cycle into
// the result queue (OUT_DEPTH entries) while that queue has room, so a message
// yields one beat without a response and 14 to 22 beats with one; that single
// beat-per-cycle back end sets the sustained rate when responses follow each
// other closely. The first beat of a message passes through the job queue and then the result queue.
`default_nettype none

module sysex_device_query_responder
    import sxq_pkg::*;
#(
    parameter int JOB_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    input  wire logic [3:0] cable,
    output logic            empty,
    input  wire logic       pop,
    output logic            item_kind,
    output logic            handled,
    output logic [7:0]      frame_byte,
    output logic [3:0]      out_cable,
    output logic            last
);

    logic [7:0] own_id_reg, boot_id_reg;
    logic       job_push, job_pop, job_full, job_empty;
    job_t       job_in, job_head;
    logic       out_push, out_full;
    out_item_t  item_in, item_head;

    logic [$bits(job_t)-1:0]      job_head_bits;
    logic [$bits(out_item_t)-1:0] item_head_bits;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg  <= OWN_ID_RESET;
            boot_id_reg <= BOOT_ID_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OWN_ID:  own_id_reg  <= cfg_data;
                CFG_BOOT_ID: boot_id_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign full = job_full;

    sxq_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .own_id         (own_id_reg),
        .boot_id        (boot_id_reg),
        .push           (push),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .cable          (cable),
        .job_full       (job_full),
        .job_push       (job_push),
        .job            (job_in)
    );

    sxq_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_head_bits),
        .empty     (job_empty)
    );

    assign job_head = job_t'(job_head_bits);

    sxq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .own_id    (own_id_reg),
        .job_valid (!job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (item_in)
    );

    sxq_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (item_in),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (item_head_bits),
        .empty     (empty)
    );

    // Result ports
    assign item_head  = out_item_t'(item_head_bits);
    assign item_kind  = item_head.item_kind;
    assign handled    = item_head.handled;
    assign frame_byte = item_head.frame_byte;
    assign out_cable  = item_head.out_cable;
    assign last       = item_head.last;

endmodule

`default_nettype wire

// ===== hdl/sxq_fifo.sv =====
// Small register-based queue, generic in width and depth (depth >= 2).
// Standalone; used for the job queue and the result queue.
`default_nettype none

module sxq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill-level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sxq_front.sv =====
// Front end: tracks byte position, checks the header, captures id fields
// and classifies each finished message into a job. Uses sxq_pkg.
`default_nettype none

module sxq_front
    import sxq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] own_id,
    input  wire logic [7:0] boot_id,
    input  wire logic       push,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    input  wire logic [3:0] cable,
    input  wire logic       job_full,
    output logic            job_push,
    output job_t            job
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic [7:0]       proto_reg, proto_next;
    logic [7:0]       inst_reg, inst_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       query_reg, query_next;
    logic             accept;
    logic [7:0]       hdr_expect;
    logic             long_enough, is_own, is_boot, is_query;

    assign accept   = push && !job_full;
    assign job_push = accept && end_of_message;

    // Expected header byte at this position
    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    hdr_expect = SYX_START;
            2'd1:    hdr_expect = HDR_BYTE1;
            2'd2:    hdr_expect = HDR_BYTE2;
            default: hdr_expect = HDR_BYTE3;
        endcase
    end

    // Message state update for the current beat
    always_comb
    begin
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        proto_next  = proto_reg;
        inst_next   = inst_reg;
        cmd_next    = cmd_reg;
        query_next  = query_reg;
        if (accept)
        begin
            if (pos_reg < POS_PROTO)
            begin
                if (data_byte != hdr_expect)
                begin
                    hdr_ok_next = 1'b0;
                end
            end
            else
            begin
                case (pos_reg)
                    POS_PROTO: proto_next = data_byte;
                    POS_INST:  inst_next  = data_byte;
                    POS_CMD:   cmd_next   = data_byte;
                    POS_QUERY: query_next = data_byte;
                    default:   ;
                endcase
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Classification on the last byte
    assign long_enough = (pos_reg >= POS_QUERY);
    assign is_own      = (proto_next == own_id);
    assign is_boot     = (proto_next == boot_id);
    assign is_query    = (cmd_next == CMD_QUERY) || (cmd_next == CMD_QUERY_ALT);

    always_comb
    begin
        job.handled       = long_enough && hdr_ok_next && (is_own || is_boot);
        job.respond       = job.handled && !is_boot && is_own && is_query;
        job.instance_byte = inst_next;
        job.cable         = cable;
        case (query_next)
            QRY_BOARD:   job.str_sel = STR_BOARD;
            QRY_CORE:    job.str_sel = STR_CORE;
            QRY_CHIP:    job.str_sel = STR_CHIP;
            QRY_SERIAL:  job.str_sel = STR_SERIAL;
            QRY_FLASH:   job.str_sel = STR_FLASH;
            QRY_RAM:     job.str_sel = STR_RAM;
            QRY_VERSION: job.str_sel = STR_VERSION;
            default:     job.str_sel = STR_NAME;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            proto_reg  <= '0;
            inst_reg   <= '0;
            cmd_reg    <= '0;
            query_reg  <= '0;
        end
        else if (job_push)
        begin
            // Message done: start clean for the next one
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            proto_reg  <= '0;
            inst_reg   <= '0;
            cmd_reg    <= '0;
            query_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            proto_reg  <= proto_next;
            inst_reg   <= inst_next;
            cmd_reg    <= cmd_next;
            query_reg  <= query_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sxq_back.sv =====
// Back end: takes one job at a time and emits the verdict beat followed, for a
// job that responds, by the response frame, one beat per cycle while the result queue has room. Uses sxq_pkg.
`default_nettype none

module sxq_back
    import sxq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] own_id,
    input  wire logic       job_valid,
    input  wire job_t       job,
    output logic            job_pop,
    input  wire logic       out_full,
    output logic            out_push,
    output out_item_t       out_item
);

    // Beat positions within one result group
    localparam logic [FRAME_IDX_W-1:0] IDX_VERDICT = 5'd0;
    localparam logic [FRAME_IDX_W-1:0] IDX_START   = 5'd1;
    localparam logic [FRAME_IDX_W-1:0] IDX_HDR1    = 5'd2;
    localparam logic [FRAME_IDX_W-1:0] IDX_HDR2    = 5'd3;
    localparam logic [FRAME_IDX_W-1:0] IDX_HDR3    = 5'd4;
    localparam logic [FRAME_IDX_W-1:0] IDX_ID      = 5'd5;
    localparam logic [FRAME_IDX_W-1:0] IDX_INST    = 5'd6;
    localparam logic [FRAME_IDX_W-1:0] IDX_RESP    = 5'd7;
    localparam logic [FRAME_IDX_W-1:0] IDX_STR     = 5'd8;

    logic [FRAME_IDX_W-1:0] idx_reg, idx_next;
    logic [FRAME_IDX_W-1:0] frame_end;
    logic [STR_LEN_W-1:0]   str_pos;
    logic                   go, last_beat;

    assign go        = job_valid && !out_full;
    assign frame_end = IDX_STR + FRAME_IDX_W'(str_len(job.str_sel));
    assign last_beat = job.respond ? (idx_reg == frame_end) : 1'b1;
    assign str_pos   = STR_LEN_W'(idx_reg - IDX_STR);
    assign out_push  = go;
    assign job_pop   = go && last_beat;

    // Beat index within the current job
    always_comb
    begin
        idx_next = idx_reg;
        if (go)
        begin
            idx_next = last_beat ? IDX_VERDICT : idx_reg + 1'b1;
        end
    end

    // Beat contents
    always_comb
    begin
        out_item.item_kind = (idx_reg != IDX_VERDICT);
        out_item.handled   = job.handled;
        out_item.out_cable = job.cable;
        out_item.last      = last_beat;
        case (idx_reg)
            IDX_VERDICT: out_item.frame_byte = 8'h00;
            IDX_START:   out_item.frame_byte = SYX_START;
            IDX_HDR1:    out_item.frame_byte = HDR_BYTE1;
            IDX_HDR2:    out_item.frame_byte = HDR_BYTE2;
            IDX_HDR3:    out_item.frame_byte = HDR_BYTE3;
            IDX_ID:      out_item.frame_byte = own_id;
            IDX_INST:    out_item.frame_byte = job.instance_byte;
            IDX_RESP:    out_item.frame_byte = RESP_CODE;
            default:
            begin
                if (idx_reg == frame_end)
                begin
                    out_item.frame_byte = SYX_END;
                end
                else
                begin
                    out_item.frame_byte = str_char(job.str_sel, str_pos);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= IDX_VERDICT;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sxq_checker.sv =====
// Port-level checks for the device query responder, bound to its top level.
// Depends only on the top level's port names.
`default_nettype none

module sxq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pop,
    input wire logic       empty,
    input wire logic       item_kind,
    input wire logic       handled,
    input wire logic [7:0] frame_byte,
    input wire logic       last
);

    // Nothing waits on the result side once reset has been seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty in reset");

    // A verdict beat carries no frame byte
    a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !item_kind) |-> (frame_byte == 8'h00))
        else $error("verdict beat with nonzero frame byte");

    // Frame bytes only follow a handled message
    a_frame_handled: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && item_kind) |-> handled)
        else $error("frame beat for an unhandled message");

    // An unhandled verdict closes its group
    a_unhandled_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !item_kind && !handled) |-> last)
        else $error("unhandled verdict not marked last");

    // A waiting beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(last)))
        else $error("waiting result beat changed");

endmodule

bind sysex_device_query_responder sxq_checker u_sxq_checker (.*);

`default_nettype wire
